// File: hw/rtl/gated_volume_fade_ramp_top_defines.svh
// Assertion macros for the volume fade ramp checker.
// Used by gvfr_chk.sv; no other dependencies.
`ifndef GATED_VOLUME_FADE_RAMP_TOP_DEFINES_SVH
`define GATED_VOLUME_FADE_RAMP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define GVFR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define GVFR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/gvfr_pkg.sv
// Shared types and constants for the volume fade ramp.
// No dependencies; imported by every module of the block.
package gvfr_pkg;

  // Default sizes
  localparam int TIME_BITS_DEF       = 24;
  localparam int LEVEL_FRAC_BITS_DEF = 16;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Fade direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_IN   = 2'd1;
  localparam logic [1:0] DIR_OUT  = 2'd2;

  // Event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_ADD     = 3'd1;
  localparam logic [2:0] EV_STOP    = 3'd2;
  localparam logic [2:0] EV_MUTE    = 3'd3;
  localparam logic [2:0] EV_UNMUTE  = 3'd4;
  localparam logic [2:0] EV_PAUSE   = 3'd5;
  localparam logic [2:0] EV_UNPAUSE = 3'd6;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/gvfr_div.sv
// Restoring divider, one quotient bit per cycle, for timer / duration.
// Depends on gvfr_pkg. Requires num < den, so the quotient is pure fraction.
module gvfr_div import gvfr_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] num,
  input  logic [TIME_BITS-1:0] den,
  output div_stat_t            stat,
  output logic [FRAC_BITS-1:0] quot
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [TIME_BITS-1:0] den_r, den_nxt;
  logic [FRAC_BITS-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [TIME_BITS:0]   shifted;
  logic [TIME_BITS:0]   diff;
  logic                 fits;

  // One trial subtract per cycle
  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      quot_nxt = '0;
      cnt_nxt  = CNT_W'(FRAC_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      quot_nxt = {quot_r[FRAC_BITS-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

// File: hw/rtl/gated_volume_fade_ramp_top.sv
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_stall    command, delta_ticks, fade_kind, event_kind,
//                                    start_level, fade_length
// out_     out  out_valid/out_stall  level, done_res, running, held_event,
//                                    start_taken
// One transaction in, one transaction out.
// A tick that divides passes through S_DIV, waiting on the bit-serial divider, then S_RES.
// A start with a ramp passes through one multiply stage (S_MUL), then S_RES; others go to S_RES.
// The input stalls while an item is in work; the output register lets the next
// item enter while a result waits. Synchronous active-low reset clears all state
// but ramp_r and the output payload. Depends on gvfr_pkg and gvfr_div.
module gated_volume_fade_ramp_top import gvfr_pkg::*; #(
  parameter int TIME_BITS       = TIME_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic [15:0]                in_delta_ticks,
  input  logic [1:0]                 in_fade_kind,
  input  logic [2:0]                 in_event_kind,
  input  logic [LEVEL_FRAC_BITS:0]   in_start_level,
  input  logic [TIME_BITS-1:0]       in_fade_length,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LEVEL_FRAC_BITS:0]   out_level,
  output logic                       out_done_res,
  output logic                       out_running,
  output logic [2:0]                 out_held_event,
  output logic                       out_start_taken
);

  localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
  localparam int EL_W    = TIME_BITS + 1;
  localparam int SUM_W   = ((EL_W > 16) ? EL_W : 16) + 1;
  localparam int PROD_W  = TIME_BITS + LEVEL_W;
  localparam logic [LEVEL_W-1:0] ONE_LVL = LEVEL_W'(1) << LEVEL_FRAC_BITS;
  localparam logic [EL_W-1:0]    EL_MAX  = '1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_RES  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [1:0]             dir_r, dir_nxt;
  logic [2:0]             act_ev_r, act_ev_nxt;
  logic [TIME_BITS-1:0]   len_r, len_nxt;
  logic [EL_W-1:0]        elapsed_r, elapsed_nxt;
  logic [LEVEL_W-1:0]     vol_r, vol_nxt;
  logic                   fin_r, fin_nxt;
  logic                   act_r, act_nxt;
  logic                   taken_r, taken_nxt;
  logic [LEVEL_W-1:0]     ramp_r, ramp_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]     out_level_r;
  logic                   out_done_r, out_run_r, out_taken_r;
  logic [2:0]             out_ev_r;
  logic                   out_load;

  logic                   in_acc;
  logic                   gate_ok;
  logic [SUM_W-1:0]       sum_w;
  logic [EL_W-1:0]        sum_sat;
  logic                   reach;
  logic [LEVEL_W-1:0]     lvl_sat;
  logic [1:0]             dir_new;
  logic [PROD_W-1:0]      prod;
  logic [LEVEL_W-1:0]     prog;

  logic                   div_start;
  div_stat_t              div_stat;
  logic [LEVEL_FRAC_BITS-1:0] div_quot;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);

  // Event gating: add/stop always pass, all pass with no event held, pairs pass their owner
  assign gate_ok = (in_event_kind == EV_ADD) || (in_event_kind == EV_STOP) ||
                   (act_ev_r == EV_NONE) ||
                   ((act_ev_r == EV_MUTE) &&
                    ((in_event_kind == EV_MUTE) || (in_event_kind == EV_UNMUTE))) ||
                   ((act_ev_r == EV_PAUSE) &&
                    ((in_event_kind == EV_PAUSE) || (in_event_kind == EV_UNPAUSE)));

  // Timer advance with saturation
  assign sum_w   = SUM_W'(elapsed_r) + SUM_W'(in_delta_ticks);
  assign sum_sat = (sum_w > SUM_W'(EL_MAX)) ? EL_MAX : sum_w[EL_W-1:0];
  assign reach   = sum_sat >= EL_W'(len_r);

  // Start operands
  assign lvl_sat = (in_start_level > ONE_LVL) ? ONE_LVL : in_start_level;
  assign dir_new = ((in_fade_kind == DIR_IN) || (in_fade_kind == DIR_OUT)) ?
                   in_fade_kind : DIR_NONE;

  // Resume point: length * ramp, registered into the timer
  assign prod = PROD_W'(len_r) * PROD_W'(ramp_r);

  // Divider result to level
  assign prog = {1'b0, div_quot};

  assign div_start = in_acc && (in_command == CMD_TICK) && (dir_r != DIR_NONE) &&
                     !fin_r && !reach;

  gvfr_div #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_sat[TIME_BITS-1:0]),
    .den   (len_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  assign out_load = (state_r == S_RES) && (!out_valid_r || !out_stall);

  // Sequencer and fade state
  always_comb begin
    state_nxt   = state_r;
    dir_nxt     = dir_r;
    act_ev_nxt  = act_ev_r;
    len_nxt     = len_r;
    elapsed_nxt = elapsed_r;
    vol_nxt     = vol_r;
    fin_nxt     = fin_r;
    act_nxt     = act_r;
    taken_nxt   = taken_r;
    ramp_nxt    = ramp_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          taken_nxt = 1'b0;
          state_nxt = S_RES;
          case (in_command)
            CMD_TICK: begin
              if ((dir_r != DIR_NONE) && !fin_r) begin
                elapsed_nxt = sum_sat;
                if (reach) begin
                  fin_nxt = 1'b1;
                  vol_nxt = (dir_r == DIR_IN) ? ONE_LVL : '0;
                end else begin
                  state_nxt = S_DIV;
                end
              end
            end
            CMD_START: begin
              if (gate_ok) begin
                taken_nxt   = 1'b1;
                dir_nxt     = dir_new;
                act_ev_nxt  = in_event_kind;
                len_nxt     = in_fade_length;
                act_nxt     = 1'b1;
                fin_nxt     = 1'b0;
                elapsed_nxt = '0;
                vol_nxt     = '0;
                ramp_nxt    = (dir_new == DIR_IN) ? lvl_sat : ONE_LVL - lvl_sat;
                if (dir_new != DIR_NONE) begin
                  if (in_fade_length == '0) begin
                    fin_nxt = 1'b1;
                    vol_nxt = (dir_new == DIR_IN) ? ONE_LVL : '0;
                  end else begin
                    vol_nxt   = lvl_sat;
                    state_nxt = S_MUL;
                  end
                end
              end
            end
            CMD_CLEAR: begin
              dir_nxt     = DIR_NONE;
              act_ev_nxt  = EV_NONE;
              len_nxt     = '0;
              elapsed_nxt = '0;
              vol_nxt     = '0;
              fin_nxt     = 1'b0;
              act_nxt     = 1'b0;
            end
            default: begin
              // unused command: report state as is
            end
          endcase
        end
      end
      S_MUL: begin
        elapsed_nxt = prod[LEVEL_FRAC_BITS +: EL_W];
        state_nxt   = S_RES;
      end
      S_DIV: begin
        if (div_stat.done) begin
          vol_nxt   = (dir_r == DIR_IN) ? prog : ONE_LVL - prog;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= DIR_NONE;
      act_ev_r    <= EV_NONE;
      len_r       <= '0;
      elapsed_r   <= '0;
      vol_r       <= '0;
      fin_r       <= 1'b0;
      act_r       <= 1'b0;
      taken_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      act_ev_r    <= act_ev_nxt;
      len_r       <= len_nxt;
      elapsed_r   <= elapsed_nxt;
      vol_r       <= vol_nxt;
      fin_r       <= fin_nxt;
      act_r       <= act_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operand and result payload registers
  always_ff @(posedge clk) begin
    ramp_r <= ramp_nxt;
    if (out_load) begin
      out_level_r <= vol_r;
      out_done_r  <= fin_r;
      out_run_r   <= act_r;
      out_ev_r    <= act_ev_r;
      out_taken_r <= taken_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_level       = out_level_r;
  assign out_done_res    = out_done_r;
  assign out_running     = out_run_r;
  assign out_held_event  = out_ev_r;
  assign out_start_taken = out_taken_r;

endmodule

// File: hw/rtl/gvfr_chk.sv
// Port-level checker for the volume fade ramp, with its bind to the top level.
// Depends on gvfr_pkg and gated_volume_fade_ramp_top_defines.svh.
`include "gated_volume_fade_ramp_top_defines.svh"

module gvfr_chk import gvfr_pkg::*; #(
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [LEVEL_FRAC_BITS:0] out_level,
  input logic                     out_done_res,
  input logic                     out_running,
  input logic [2:0]               out_held_event,
  input logic                     out_start_taken
);

  localparam int LVL_W = LEVEL_FRAC_BITS + 1;
  localparam logic [LEVEL_FRAC_BITS:0] ONE_LVL = LVL_W'(1) << LEVEL_FRAC_BITS;

  // A stalled result stays offered
  `GVFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
                    "result dropped under stall")

  // One transaction at a time: the input closes after an accept
  `GVFR_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && !in_stall, in_stall,
                    "input open while item in work")

  // Level never leaves 0..1
  `GVFR_ASSERT_NOW(a_level_range, clk, rst_n, out_valid, out_level <= ONE_LVL,
                   "level above one")

  // An accepted start marks the block running
  `GVFR_ASSERT_NOW(a_taken_run, clk, rst_n, out_valid && out_start_taken, out_running,
                   "start taken but not running")

  // Without an activation since clear, all state reads as cleared
  `GVFR_ASSERT_NOW(a_idle_clear, clk, rst_n, out_valid && !out_running,
                   (out_level == '0) && !out_done_res && (out_held_event == EV_NONE),
                   "state not clear while not running")

endmodule

bind gated_volume_fade_ramp_top gvfr_chk #(
  .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
) u_gvfr_chk (.*);
